### hdl/mavg_pkg.sv
// Moving average window: shared constants and controller/datapath interface types.
// No dependencies.
package mavg_pkg;

    localparam int FRAC_BITS     = 8;
    localparam int LEN_BITS      = 7;
    localparam int WIN_LEN_RESET = 8;

    typedef struct packed {
        logic accept;
        logic update;
        logic load_div;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } ctrl_status_t;

endpackage

### hdl/moving_average_window_top.sv
// Moving average window top level: controller, datapath and configuration port.
// Depends on mavg_pkg, mavg_ctrl and mavg_dp.
//
// Usage:
//   Input channel s_valid/s_ready carries one signed sample per transfer; each
//   sample yields one result on m_valid/m_ready: m_average (mean of the held
//   samples, 8 fraction bits, truncated toward zero) and m_samples_held.
//   cfg_we with cfg_window_length sets the window (0 acts as 1, values above
//   MAX_WINDOW saturate) and clears the history; write it only while idle.
//   A new sample is taken only after the previous result has been loaded for
//   output; the time per sample is set by the bit-serial divider, which steps
//   through every dividend bit, plus the controller's other states.
//   Reset (aresetn low, synchronous) empties the window, sets its length to 8
//   and drops m_valid. A result waits in the output register while the
//   receiver stalls; the next sample is still taken and processed, and only
//   its final load waits for the output register to free.
module moving_average_window_top
    import mavg_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [LEN_BITS-1:0]                     cfg_window_length,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [SAMPLE_BITS-1:0]           s_sample,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] m_average,
    output logic [$clog2(MAX_WINDOW+1)-1:0]         m_samples_held
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    mavg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mavg_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_we),
        .cfg_window_length (cfg_window_length),
        .s_sample          (s_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_average         (m_average),
        .m_samples_held    (m_samples_held)
    );

endmodule

### hdl/mavg_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mavg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module mavg_div #(
    parameter int NUM_BITS = 30,
    parameter int DEN_BITS = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_BITS-1:0] dividend,
    input  logic [DEN_BITS-1:0] divisor,
    output logic [NUM_BITS-1:0] quotient,
    output logic                done
);

    localparam int CNT_W = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   trial;
    logic                qbit;

    always_comb begin
        trial     = {rem_reg, quo_reg[NUM_BITS-1]};
        qbit      = (trial >= {1'b0, den_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CNT_W'(NUM_BITS);
        end else if (cnt_reg != '0) begin
            quo_next  = {quo_reg[NUM_BITS-2:0], qbit};
            rem_next  = qbit ? DEN_BITS'(trial - {1'b0, den_reg}) : trial[DEN_BITS-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

`ifndef SYNTH
    a_start_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> cnt_reg == CNT_W'(NUM_BITS))
        else $error("divider did not load its step count");
    a_done_after_step: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> $past(cnt_reg) == CNT_W'(1))
        else $error("divider done without a final step");
`endif

endmodule

### hdl/mavg_ctrl.sv
// Moving average controller: sequences accept, window update, divide and output load.
// Depends on mavg_pkg.
module mavg_ctrl
    import mavg_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load_div = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && cmd.update)
        else $error("transfer did not start a window update");
`endif

endmodule

### hdl/mavg_dp.sv
// Moving average datapath: sample ring, running sum, divider and output register.
// Depends on mavg_pkg, mavg_ram and mavg_div.
module mavg_dp
    import mavg_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ctrl_cmd_t                         cmd,
    output ctrl_status_t                      status,
    input  logic                              cfg_we,
    input  logic [LEN_BITS-1:0]               cfg_window_length,
    input  logic signed [SAMPLE_BITS-1:0]     s_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] m_average,
    output logic [$clog2(MAX_WINDOW+1)-1:0]   m_samples_held
);

    localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
    localparam int WP_BITS  = $clog2(MAX_WINDOW);
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int DIV_BITS = SUM_BITS + FRAC_BITS;
    localparam int AVG_BITS = SAMPLE_BITS + FRAC_BITS;
    localparam int LW       = (LEN_BITS > CNT_BITS) ? LEN_BITS : CNT_BITS;
    localparam int LEN_RST  = (WIN_LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_LEN_RESET;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [CNT_BITS-1:0]           held_reg, held_next;
    logic [CNT_BITS-1:0]           len_reg, len_next;
    logic [WP_BITS-1:0]            wp_reg, wp_next;
    logic [CNT_BITS-1:0]           wp_inc;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic                          full;
    logic [LW-1:0]                 cfg_ext;
    logic                          neg_reg;
    logic [SUM_BITS-1:0]           mag;
    logic [DIV_BITS-1:0]           quotient;
    logic [DIV_BITS-1:0]           avg_full;
    logic                          div_done;
    logic                          m_valid_reg;
    logic [AVG_BITS-1:0]           avg_reg;
    logic [CNT_BITS-1:0]           held_out_reg;

    mavg_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (wp_reg),
        .wdata (sample_reg),
        .re    (cmd.accept),
        .raddr (wp_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        cfg_ext = LW'(cfg_window_length);
        if (cfg_ext == '0) begin
            len_next = CNT_BITS'(1);
        end else if (cfg_ext > LW'(MAX_WINDOW)) begin
            len_next = CNT_BITS'(MAX_WINDOW);
        end else begin
            len_next = cfg_ext[CNT_BITS-1:0];
        end
    end

    always_comb begin
        full      = (held_reg >= len_reg);
        held_next = full ? held_reg : held_reg + CNT_BITS'(1);
        sum_next  = sum_reg + SUM_BITS'(sample_reg)
                  - (full ? SUM_BITS'($signed(ram_rdata)) : SUM_BITS'(0));
        wp_inc    = CNT_BITS'(wp_reg) + CNT_BITS'(1);
        wp_next   = (wp_inc >= len_reg) ? '0 : wp_inc[WP_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= CNT_BITS'(LEN_RST);
            held_reg <= '0;
            wp_reg   <= '0;
            sum_reg  <= '0;
        end else if (cfg_we) begin
            len_reg  <= len_next;
            held_reg <= '0;
            wp_reg   <= '0;
            sum_reg  <= '0;
        end else if (cmd.update) begin
            held_reg <= held_next;
            wp_reg   <= wp_next;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg <= s_sample;
        end
        if (cmd.load_div) begin
            neg_reg <= sum_reg[SUM_BITS-1];
        end
    end

    // |sum| scaled by 2^FRAC_BITS, divided by the held count
    assign mag = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);

    mavg_div #(
        .NUM_BITS (DIV_BITS),
        .DEN_BITS (CNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.load_div),
        .dividend ({mag, FRAC_BITS'(0)}),
        .divisor  (held_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign avg_full = neg_reg ? (~quotient + DIV_BITS'(1)) : quotient;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            avg_reg      <= avg_full[AVG_BITS-1:0];
            held_out_reg <= held_reg;
        end
    end

    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_average       = $signed(avg_reg);
    assign m_samples_held  = held_out_reg;

`ifndef SYNTH
    a_held_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= len_reg)
        else $error("held count exceeds window length");
    a_wp_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_BITS'(wp_reg) < len_reg)
        else $error("write position outside window");
    a_out_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_samples_held != '0)
        else $error("result loaded with empty window");
`endif

endmodule
